@@ src/pemf_pkg.sv @@
// ============================================================================
// pemf_pkg
// Shared types and constants of the pointer event mailbox FIFO.
// ============================================================================
package pemf_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;

  // Item kinds
  localparam logic CMD_MOUSE = 1'b0;
  localparam logic CMD_PORT  = 1'b1;

  // Port commands (low byte of ECX)
  localparam logic [7:0] PC_VERSION = 8'd10;
  localparam logic [7:0] PC_DATA    = 8'd39;
  localparam logic [7:0] PC_STATUS  = 8'd40;
  localparam logic [7:0] PC_COMMAND = 8'd41;

  // Magic words and subcommands
  localparam logic [31:0] MAGIC_VERSION = 32'h564D_5868;
  localparam logic [31:0] SUB_READ_ID   = 32'h4541_4552;
  localparam logic [31:0] ID_WORD       = 32'h3442_554A;
  localparam logic [31:0] SUB_DISABLE   = 32'h0000_00F5;
  localparam logic [31:0] SUB_RELATIVE  = 32'h4C45_5252;
  localparam logic [31:0] SUB_ABSOLUTE  = 32'h5342_4152;

  localparam logic [15:0] STATUS_DISABLED = 16'hFFFF;
  localparam logic [31:0] MAX_READ        = 32'd6;

  // Guest register indexes
  localparam logic [2:0] REG_EAX = 3'd0;
  localparam logic [2:0] REG_EBX = 3'd1;

  // Queued event word slots
  localparam logic [1:0] SLOT_STATUS = 2'd0;
  localparam logic [1:0] SLOT_X      = 2'd1;
  localparam logic [1:0] SLOT_Y      = 2'd2;
  localparam logic [1:0] SLOT_DZ     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_POP,
    S_DONE
  } pemf_state_t;

  // Kind of the single closing word
  typedef enum logic [2:0] {
    RK_EMPTY,
    RK_PS2,
    RK_WAKE,
    RK_MAGIC,
    RK_STATUS
  } pemf_res_kind_t;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        port_command;
    logic [31:0]       port_value;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0]  wheel_dz;
    logic [2:0]        buttons;
  } pemf_in_word_t;

  typedef struct packed {
    logic              reg_valid;
    logic [2:0]        reg_index;
    logic [31:0]       reg_value;
    logic              ps2_valid;
    logic signed [15:0] ps2_dx;
    logic signed [15:0] ps2_dy;
    logic signed [7:0]  ps2_dz;
    logic [2:0]        ps2_buttons;
    logic              last;
  } pemf_out_word_t;

endpackage

@@ src/pemf_intf.sv @@
// ============================================================================
// pemf channel interfaces
// Valid/ready channels for input items and result words.
// ============================================================================
interface pemf_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         port_command;
  logic [31:0]        port_value;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic signed [7:0]  wheel_dz;
  logic [2:0]         buttons;

  modport source (
    output valid, cmd, port_command, port_value, move_x, move_y, wheel_dz, buttons,
    input  ready
  );
  modport sink (
    input  valid, cmd, port_command, port_value, move_x, move_y, wheel_dz, buttons,
    output ready
  );
endinterface

interface pemf_out_if;
  logic               valid;
  logic               ready;
  logic               reg_valid;
  logic [2:0]         reg_index;
  logic [31:0]        reg_value;
  logic               ps2_valid;
  logic signed [15:0] ps2_dx;
  logic signed [15:0] ps2_dy;
  logic signed [7:0]  ps2_dz;
  logic [2:0]         ps2_buttons;
  logic               last;

  modport source (
    output valid, reg_valid, reg_index, reg_value, ps2_valid, ps2_dx, ps2_dy, ps2_dz,
           ps2_buttons, last,
    input  ready
  );
  modport sink (
    input  valid, reg_valid, reg_index, reg_value, ps2_valid, ps2_dx, ps2_dy, ps2_dz,
           ps2_buttons, last,
    output ready
  );
endinterface

@@ src/pointer_event_mailbox_fifo_core.sv @@
// ============================================================================
// pointer_event_mailbox_fifo_core
// Paravirtual pointer device: event word ring FIFO behind a command port.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per word. cmd=0 is a mouse event (move_x/move_y/
//            wheel_dz/buttons), cmd=1 a port access (port_command,
//            port_value). Ready is high only while the core is idle.
//   out_ch : result words; each item yields 1 to 6 words, the final one
//            flagged with last. reg_* words target guest registers,
//            ps2_* words are PS/2 events (pass-through or wake).
//   Flow   : accept -> decode, then an enabled mouse event with room left
//            writes 4 FIFO words (1 per cycle) and loads its wake word; a
//            data read of N words goes through one read port with registered
//            data, each next read overlapping the hand-off of the word before;
//            other items load their closing word. The core then goes idle.
//   Stall  : results sit in a single output register; while it is full and
//            the receiver holds ready low, the core waits in place before
//            loading a result word. Once the closing word is loaded the
//            core is idle and takes the next item even if that word waits.
//   Reset  : synchronous, active low. Pointers, fill count, enable and
//            absolute mode clear; the FIFO storage itself is not cleared
//            (reads are always bounded by the fill count).
// ============================================================================
module pointer_event_mailbox_fifo_core #(
  parameter int QUEUE_DEPTH = pemf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  pemf_in_if.sink    in_ch,
  pemf_out_if.source out_ch
);
  import pemf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST     = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ROOM_EVT = CNT_W'(QUEUE_DEPTH - 4);

  // FIFO storage, one write and one registered read port
  logic [31:0] mem [QUEUE_DEPTH];
  logic [31:0] mem_q_r;
  logic        mem_we;
  logic        mem_re;
  logic [31:0] mem_wd;

  pemf_state_t    state_r, state_nxt;
  pemf_res_kind_t kind_r, kind_nxt;
  pemf_in_word_t  item_r, item_nxt;
  pemf_out_word_t out_word_r, out_word_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     idx_r, idx_nxt;   // push slot / destination register
  logic [2:0]     cnt_r, cnt_nxt;   // last push slot / pops left
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic           enabled_r, enabled_nxt;
  logic           absolute_r, absolute_nxt;

  logic           out_free;
  logic           in_accept;
  pemf_out_word_t done_word;
  logic [31:0]    x_word, y_word, dz_word;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Event coordinates: sign-extended, doubled in absolute mode; wheel delta negated
  assign x_word  = absolute_r ? {{15{item_r.move_x[15]}}, item_r.move_x, 1'b0}
                              : {{16{item_r.move_x[15]}}, item_r.move_x};
  assign y_word  = absolute_r ? {{15{item_r.move_y[15]}}, item_r.move_y, 1'b0}
                              : {{16{item_r.move_y[15]}}, item_r.move_y};
  assign dz_word = 32'd0 - {{24{item_r.wheel_dz[7]}}, item_r.wheel_dz};

  // Word written to the FIFO in the current push slot
  always_comb begin
    case (idx_r[1:0])
      SLOT_STATUS: begin
        // read-id pushes the id word; events push the button mask
        mem_wd = (item_r.cmd == CMD_PORT) ? ID_WORD
               : {26'd0, item_r.buttons[0], item_r.buttons[1], item_r.buttons[2], 3'd0};
      end
      SLOT_X:  mem_wd = x_word;
      SLOT_Y:  mem_wd = y_word;
      SLOT_DZ: mem_wd = dz_word;
      default: mem_wd = '0;
    endcase
  end

  // Closing word of an item
  always_comb begin
    done_word      = '0;
    done_word.last = 1'b1;
    case (kind_r)
      RK_PS2: begin
        done_word.ps2_valid   = 1'b1;
        done_word.ps2_dx      = item_r.move_x;
        done_word.ps2_dy      = item_r.move_y;
        done_word.ps2_dz      = item_r.wheel_dz;
        done_word.ps2_buttons = item_r.buttons;
      end
      RK_WAKE: begin
        done_word.ps2_valid = 1'b1;
        done_word.ps2_dx    = 16'sd1;
      end
      RK_MAGIC: begin
        done_word.reg_valid = 1'b1;
        done_word.reg_index = REG_EBX;
        done_word.reg_value = MAGIC_VERSION;
      end
      RK_STATUS: begin
        done_word.reg_valid = 1'b1;
        done_word.reg_index = REG_EAX;
        done_word.reg_value = {(enabled_r ? 16'd0 : STATUS_DISABLED), 16'(fill_r)};
      end
      default: ;
    endcase
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    item_nxt      = item_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    fill_nxt      = fill_r;
    enabled_nxt   = enabled_r;
    absolute_nxt  = absolute_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_nxt.cmd          = in_ch.cmd;
          item_nxt.port_command = in_ch.port_command;
          item_nxt.port_value   = in_ch.port_value;
          item_nxt.move_x       = in_ch.move_x;
          item_nxt.move_y       = in_ch.move_y;
          item_nxt.wheel_dz     = in_ch.wheel_dz;
          item_nxt.buttons      = in_ch.buttons;
          state_nxt             = S_EXEC;
        end
      end

      S_EXEC: begin
        kind_nxt  = RK_EMPTY;
        state_nxt = S_DONE;
        idx_nxt   = 3'd0;
        if (item_r.cmd == CMD_MOUSE) begin
          if (!enabled_r) begin
            kind_nxt = RK_PS2;
          end else if (fill_r <= CNT_ROOM_EVT) begin
            kind_nxt  = RK_WAKE;
            cnt_nxt   = 3'd3;
            state_nxt = S_PUSH;
          end
        end else begin
          unique case (item_r.port_command)
            PC_VERSION: kind_nxt = RK_MAGIC;
            PC_STATUS:  kind_nxt = RK_STATUS;
            PC_DATA: begin
              if (item_r.port_value > MAX_READ
                  || item_r.port_value > 32'(fill_r)) begin
                enabled_nxt = 1'b0;
              end else if (item_r.port_value != 32'd0) begin
                // first read goes out now; data lands next cycle
                mem_re     = 1'b1;
                rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
                fill_nxt   = fill_r - 1'b1;
                cnt_nxt    = item_r.port_value[2:0];
                state_nxt  = S_POP;
              end
            end
            PC_COMMAND: begin
              if (item_r.port_value == SUB_READ_ID) begin
                if (fill_r < CNT_FULL) begin
                  enabled_nxt = 1'b1;
                  cnt_nxt     = 3'd0;
                  state_nxt   = S_PUSH;
                end
              end else if (item_r.port_value == SUB_DISABLE) begin
                enabled_nxt = 1'b0;
              end else if (item_r.port_value == SUB_RELATIVE) begin
                absolute_nxt = 1'b0;
              end else if (item_r.port_value == SUB_ABSOLUTE) begin
                absolute_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_PUSH: begin
        mem_we     = 1'b1;
        wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
        fill_nxt   = fill_r + 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == cnt_r) begin
          state_nxt = S_DONE;
        end
      end

      S_POP: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt           = '0;
          out_word_nxt.reg_valid = 1'b1;
          out_word_nxt.reg_index = idx_r;
          out_word_nxt.reg_value = mem_q_r;
          out_word_nxt.last      = (cnt_r == 3'd1);
          idx_nxt                = idx_r + 1'b1;
          cnt_nxt                = cnt_r - 1'b1;
          if (cnt_r == 3'd1) begin
            state_nxt = S_IDLE;
          end else begin
            // overlap the next read with this word's hand-off
            mem_re     = 1'b1;
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            fill_nxt   = fill_r - 1'b1;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = done_word;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      enabled_r   <= 1'b0;
      absolute_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      enabled_r   <= enabled_nxt;
      absolute_r  <= absolute_nxt;
    end
  end

  // Payload and sequencer scratch, no reset
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    item_r     <= item_nxt;
    out_word_r <= out_word_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
  end

  // FIFO memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_ptr_r];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reg_valid   = out_word_r.reg_valid;
  assign out_ch.reg_index   = out_word_r.reg_index;
  assign out_ch.reg_value   = out_word_r.reg_value;
  assign out_ch.ps2_valid   = out_word_r.ps2_valid;
  assign out_ch.ps2_dx      = out_word_r.ps2_dx;
  assign out_ch.ps2_dy      = out_word_r.ps2_dy;
  assign out_ch.ps2_dz      = out_word_r.ps2_dz;
  assign out_ch.ps2_buttons = out_word_r.ps2_buttons;
  assign out_ch.last        = out_word_r.last;

endmodule

@@ src/pemf_checker.sv @@
// ============================================================================
// pemf_checker
// Port-level checks of the pointer event mailbox FIFO core.
// ============================================================================
module pemf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              reg_valid,
  input logic [2:0]        reg_index,
  input logic [31:0]       reg_value,
  input logic              ps2_valid,
  input logic signed [15:0] ps2_dx,
  input logic signed [15:0] ps2_dy,
  input logic signed [7:0]  ps2_dz,
  input logic [2:0]        ps2_buttons,
  input logic              last
);

  // stalled result word holds its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  // a word targets a register or PS/2, never both
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(reg_valid && ps2_valid))
    else $error("result word carries both register and PS/2 data");

  // unused fields read zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (reg_valid || (reg_index == 3'd0 && reg_value == 32'd0))
               && (ps2_valid || (ps2_dx == 16'sd0 && ps2_dy == 16'sd0
                                 && ps2_dz == 8'sd0 && ps2_buttons == 3'd0)))
    else $error("inactive result fields not zero");

  // PS/2 words close their item
  a_ps2_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ps2_valid |-> last && reg_index == 3'd0)
    else $error("PS/2 word not marked last");

endmodule

bind pointer_event_mailbox_fifo_core pemf_checker u_pemf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .reg_valid   (out_ch.reg_valid),
  .reg_index   (out_ch.reg_index),
  .reg_value   (out_ch.reg_value),
  .ps2_valid   (out_ch.ps2_valid),
  .ps2_dx      (out_ch.ps2_dx),
  .ps2_dy      (out_ch.ps2_dy),
  .ps2_dz      (out_ch.ps2_dz),
  .ps2_buttons (out_ch.ps2_buttons),
  .last        (out_ch.last)
);
